FILE: hdl/hec_pkg.sv
// Shared types, constants and code tables for the Hamming encoder and checker.
package hec_pkg;

	localparam int DATA_BITS = 11;
	localparam int PAR_BITS  = 4;
	localparam int CW_BITS   = DATA_BITS + PAR_BITS;

	localparam logic [1:0] CFG_DATA_LENGTH = 2'd0;
	localparam logic [1:0] CFG_PARITY_ODD  = 2'd1;

	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_CHECK  = 1'b1;

	localparam logic [3:0] LEN_RESET = 4'd4;

	// codeword bit index of the m-th message bit
	localparam logic [3:0] DATA_IDX [0:DATA_BITS-1] = '{
		4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
	};

	// codeword bit index of parity bit i
	localparam logic [3:0] PAR_IDX [0:PAR_BITS-1] = '{4'd0, 4'd1, 4'd3, 4'd7};

	// positions covered by parity group i
	localparam logic [CW_BITS-1:0] GROUP_MASK [0:PAR_BITS-1] = '{
		15'h5555, 15'h6666, 15'h7878, 15'h7F80
	};

	typedef struct packed {
		logic [3:0] data_len;
		logic [2:0] par_cnt;
		logic [3:0] cw_len;
		logic       odd;
	} cfg_t;

	typedef struct packed {
		logic                req_type;
		logic [DATA_BITS-1:0] data_word;
		logic [CW_BITS-1:0]   codeword_in;
	} req_t;

	typedef struct packed {
		logic [CW_BITS-1:0] codeword_out;
		logic [2:0]         parity_count;
		logic [3:0]         syndrome;
		logic               error_found;
		logic [3:0]         error_display_index;
		logic               syndrome_beyond_length;
	} res_t;

endpackage

FILE: hdl/hec_cfg.sv
// Configuration registers and the code geometry derived from them.
module hec_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data,
	output hec_pkg::cfg_t       cfg
);

	logic [3:0] data_length_q;
	logic       parity_odd_q;
	logic [3:0] k;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= hec_pkg::LEN_RESET;
			parity_odd_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hec_pkg::CFG_DATA_LENGTH: data_length_q <= cfg_data;
				hec_pkg::CFG_PARITY_ODD:  parity_odd_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (data_length_q == 4'd0)
			k = 4'd1;
		else if (data_length_q > 4'(hec_pkg::DATA_BITS))
			k = 4'(hec_pkg::DATA_BITS);
		else
			k = data_length_q;
		cfg.data_len = k;
		if (k == 4'd1)
			cfg.par_cnt = 3'd2;
		else if (k <= 4'd4)
			cfg.par_cnt = 3'd3;
		else
			cfg.par_cnt = 3'd4;
		cfg.cw_len = k + {1'b0, cfg.par_cnt};
		cfg.odd    = parity_odd_q;
	end

endmodule

FILE: hdl/hec_core.sv
// Encode and syndrome logic for one item.
module hec_core (
	input  hec_pkg::cfg_t cfg,
	input  hec_pkg::req_t req,
	output hec_pkg::res_t res
);

	logic [hec_pkg::CW_BITS-1:0] len_mask;
	logic [hec_pkg::CW_BITS-1:0] data_pl;
	logic [hec_pkg::CW_BITS-1:0] enc_word;
	logic [hec_pkg::CW_BITS-1:0] rx_word;
	logic [3:0]                  syn;

	always_comb begin
		len_mask = 15'h7FFF >> (4'd15 - cfg.cw_len);
		data_pl  = '0;
		for (int m = 0; m < hec_pkg::DATA_BITS; m++) begin
			if (4'(m) < cfg.data_len && req.data_word[m])
				data_pl[hec_pkg::DATA_IDX[m]] = 1'b1;
		end
		enc_word = data_pl;
		rx_word  = req.codeword_in & len_mask;
		syn      = '0;
		for (int i = 0; i < hec_pkg::PAR_BITS; i++) begin
			if (3'(i) < cfg.par_cnt) begin
				enc_word[hec_pkg::PAR_IDX[i]] =
					(^(data_pl & hec_pkg::GROUP_MASK[i])) ^ cfg.odd;
				syn[i] = (^(rx_word & hec_pkg::GROUP_MASK[i])) ^ cfg.odd;
			end
		end

		res.parity_count           = cfg.par_cnt;
		res.codeword_out           = '0;
		res.syndrome               = '0;
		res.error_found            = 1'b0;
		res.error_display_index    = '0;
		res.syndrome_beyond_length = 1'b0;
		if (req.req_type == hec_pkg::REQ_ENCODE) begin
			res.codeword_out = enc_word;
		end else begin
			res.syndrome    = syn;
			res.error_found = (syn != 4'd0);
			if (syn > cfg.cw_len)
				res.syndrome_beyond_length = 1'b1;
			else if (syn != 4'd0)
				res.error_display_index = cfg.cw_len - syn + 4'd1;
		end
	end

endmodule

FILE: hdl/hamming_encode_check.sv
// Top level of the Hamming encoder and checker: input stage, logic, result stage.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid / in_ready   | req_type, data_word, codeword_in
//  out     | out_valid / out_ready | codeword_out ... syndrome_beyond_length
//
// An item is registered on entry and its result is then registered in the result stage;
// one item per cycle unless out_ready stalls, set by the input and result registers.
// Reset clears both stage valids and loads the register defaults.
// A stalled result holds both stages; in_ready follows out_ready through the chain.
module hamming_encode_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [10:0] data_word,
	input  logic [14:0] codeword_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] codeword_out,
	output logic [2:0]  parity_count,
	output logic [3:0]  syndrome,
	output logic        error_found,
	output logic [3:0]  error_display_index,
	output logic        syndrome_beyond_length
);

	hec_pkg::cfg_t cfg;
	hec_pkg::req_t req_s1;
	hec_pkg::res_t res_c;
	hec_pkg::res_t res_s2;
	logic          valid_s1;
	logic          valid_s2;
	logic          adv_s2;

	hec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hec_core u_core (
		.cfg (cfg),
		.req (req_s1),
		.res (res_c)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.req_type    <= req_type;
			req_s1.data_word   <= data_word;
			req_s1.codeword_in <= codeword_in;
		end
		if (adv_s2 && valid_s1)
			res_s2 <= res_c;
	end

	assign out_valid              = valid_s2;
	assign codeword_out           = res_s2.codeword_out;
	assign parity_count           = res_s2.parity_count;
	assign syndrome               = res_s2.syndrome;
	assign error_found            = res_s2.error_found;
	assign error_display_index    = res_s2.error_display_index;
	assign syndrome_beyond_length = res_s2.syndrome_beyond_length;

endmodule

FILE: sim/tb_top.sv
// Testbench for hamming_encode_check: encode and check traffic under random flow control.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 145;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	class hamming_tracker;
		logic [3:0]      data_len;
		logic            odd;
		hec_pkg::res_t   expected_words[$];
		int              fails;

		function new();
			data_len = hec_pkg::LEN_RESET;
			odd = 1'b0;
			fails = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [3:0] val);
			case (idx)
				hec_pkg::CFG_DATA_LENGTH: data_len = val;
				hec_pkg::CFG_PARITY_ODD:  odd = val[0];
				default: ;
			endcase
		endfunction

		function int msg_len();
			if (data_len == 4'd0)
				return 1;
			if (data_len > hec_pkg::DATA_BITS)
				return hec_pkg::DATA_BITS;
			return data_len;
		endfunction

		function int par_len();
			int k;
			k = msg_len();
			for (int r = 1; r < hec_pkg::PAR_BITS; r++)
				if (k + r + 1 <= (1 << r))
					return r;
			return hec_pkg::PAR_BITS;
		endfunction

		function int cw_len();
			return msg_len() + par_len();
		endfunction

		function logic group_par(logic [hec_pkg::CW_BITS-1:0] w, int n, int i);
			logic acc;
			acc = 1'b0;
			for (int p = 1; p <= n; p++)
				if ((p >> i) & 1)
					acc ^= w[p-1];
			return acc;
		endfunction

		function logic [hec_pkg::CW_BITS-1:0] encode_word(logic [hec_pkg::DATA_BITS-1:0] dw);
			logic [hec_pkg::CW_BITS-1:0] w;
			int n;
			int m;
			w = '0;
			n = cw_len();
			m = 0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					w[p-1] = dw[m];
					m++;
				end
			end
			for (int i = 0; i < par_len(); i++)
				if (group_par(w, n, i) ^ odd)
					w[(1 << i) - 1] = 1'b1;
			return w;
		endfunction

		function void note_request(logic rt, logic [hec_pkg::DATA_BITS-1:0] dw,
			logic [hec_pkg::CW_BITS-1:0] cw);
			hec_pkg::res_t e;
			int n;
			logic [3:0] s;
			e = '0;
			n = cw_len();
			e.parity_count = 3'(par_len());
			if (rt == hec_pkg::REQ_ENCODE) begin
				e.codeword_out = encode_word(dw);
			end else begin
				s = '0;
				for (int i = 0; i < par_len(); i++)
					s[i] = group_par(cw, n, i) ^ odd;
				e.syndrome = s;
				e.error_found = (s != 0);
				if (s > n)
					e.syndrome_beyond_length = 1'b1;
				else if (s != 0)
					e.error_display_index = 4'(n - s + 1);
			end
			expected_words.push_back(e);
		endfunction

		function void cmp(string name, int e, int a);
			if (e != a) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, e, a);
				fails++;
			end
		endfunction

		function void check_result(hec_pkg::res_t a);
			hec_pkg::res_t e;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result, expected none actual codeword %0d",
					$time, a.codeword_out);
				fails++;
				return;
			end
			e = expected_words.pop_front();
			cmp("codeword_out", e.codeword_out, a.codeword_out);
			cmp("parity_count", e.parity_count, a.parity_count);
			cmp("syndrome", e.syndrome, a.syndrome);
			cmp("error_found", e.error_found, a.error_found);
			cmp("error_display_index", e.error_display_index, a.error_display_index);
			cmp("syndrome_beyond_length", e.syndrome_beyond_length,
				a.syndrome_beyond_length);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [10:0] data_word;
	logic [14:0] codeword_in;
	logic        out_valid;
	logic        out_ready;
	logic [14:0] codeword_out;
	logic [2:0]  parity_count;
	logic [3:0]  syndrome;
	logic        error_found;
	logic [3:0]  error_display_index;
	logic        syndrome_beyond_length;

	hamming_tracker codec = new();

	hamming_encode_check u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_valid              (cfg_valid),
		.cfg_ready              (cfg_ready),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.req_type               (req_type),
		.data_word              (data_word),
		.codeword_in            (codeword_in),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.codeword_out           (codeword_out),
		.parity_count           (parity_count),
		.syndrome               (syndrome),
		.error_found            (error_found),
		.error_display_index    (error_display_index),
		.syndrome_beyond_length (syndrome_beyond_length)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_top failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			codec.check_result({codeword_out, parity_count, syndrome, error_found,
				error_display_index, syndrome_beyond_length});
	end

	initial begin
		int mode;
		int cyc;
		mode = 0;
		cyc = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (cyc % 5 != 0);
				default: out_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	task automatic push_item(input logic rt, input logic [10:0] dw, input logic [14:0] cw);
		in_valid <= 1'b1;
		req_type <= rt;
		data_word <= dw;
		codeword_in <= cw;
		do @(posedge clk); while (!in_ready);
		codec.note_request(rt, dw, cw);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (codec.pending() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		codec.set_reg(idx, val);
	endtask

	task automatic configure(input logic [3:0] len, input logic [3:0] par, input bit spare);
		drain_results();
		if ($urandom_range(0, 1)) begin
			write_reg(hec_pkg::CFG_DATA_LENGTH, len);
			write_reg(hec_pkg::CFG_PARITY_ODD, par);
		end else begin
			write_reg(hec_pkg::CFG_PARITY_ODD, par);
			write_reg(hec_pkg::CFG_DATA_LENGTH, len);
		end
		if (spare) begin
			write_reg(CFG_SPARE_A, 4'($urandom));
			write_reg(CFG_SPARE_B, 4'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		logic [10:0] dw;
		logic [15:0] junk_mask;
		logic [14:0] cw;
		logic [3:0]  flip;
		int sel;
		int n;
		sel = $urandom_range(0, 9);
		dw = 11'($urandom);
		cw = 15'($urandom);
		n = codec.cw_len();
		if (sel < 3) begin
			push_item(hec_pkg::REQ_ENCODE, dw, cw);
		end else if (sel < 7) begin
			junk_mask = (16'h7FFF << n) & 16'h7FFF;
			cw = codec.encode_word(dw) | (cw & junk_mask[14:0]);
			if ($urandom_range(0, 9) < 7) begin
				flip = 4'($urandom_range(0, n - 1));
				cw[flip] ^= 1'b1;
			end
			push_item(hec_pkg::REQ_CHECK, dw, cw);
		end else begin
			push_item(hec_pkg::REQ_CHECK, dw, cw);
		end
	endtask

	initial begin
		int cnt;
		int burst;
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= hec_pkg::CFG_DATA_LENGTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		req_type <= hec_pkg::REQ_ENCODE;
		data_word <= '0;
		codeword_in <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(hec_pkg::REQ_ENCODE, 11'h000, 15'h7FFF);
		push_item(hec_pkg::REQ_ENCODE, 11'h7FF, 15'h0000);
		push_item(hec_pkg::REQ_ENCODE, 11'h5A5, 15'h2AAA);
		push_item(hec_pkg::REQ_CHECK, 11'h7FF, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h7FFF);
		push_item(hec_pkg::REQ_CHECK, 11'h000, codec.encode_word(11'h005) ^ 15'h0004);

		configure(4'd11, 4'd1, 1'b0);
		push_item(hec_pkg::REQ_ENCODE, 11'h000, 15'h0000);
		push_item(hec_pkg::REQ_ENCODE, 11'h7FF, 15'h0000);
		push_item(hec_pkg::REQ_ENCODE, 11'h555, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h7FFF);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h2AAA);

		configure(4'd2, 4'd0, 1'b0);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'd12);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'd10);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'd5);
		push_item(hec_pkg::REQ_ENCODE, 11'h003, 15'h0000);

		configure(4'd0, 4'd1, 1'b0);
		push_item(hec_pkg::REQ_ENCODE, 11'h000, 15'h0000);
		push_item(hec_pkg::REQ_ENCODE, 11'h001, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h0007);

		configure(4'd15, 4'd14, 1'b1);
		push_item(hec_pkg::REQ_ENCODE, 11'h7FF, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h4000);

		configure(4'd1, 4'd1, 1'b0);
		push_item(hec_pkg::REQ_ENCODE, 11'h001, 15'h0000);
		push_item(hec_pkg::REQ_CHECK, 11'h000, 15'h0007);

		for (int ph = 0; ph < PHASES; ph++) begin
			if ($urandom_range(0, 5) == 0)
				configure($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(12, 15)),
					4'($urandom), 1'($urandom_range(0, 1)));
			else
				configure(4'($urandom_range(1, 11)), 4'($urandom), $urandom_range(0, 3) == 0);
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && cnt < PHASE_ITEMS; b++) begin
					random_item();
					cnt++;
				end
				if ($urandom_range(0, 9) >= 3)
					idle_cycles($urandom_range(1, 6));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (codec.fails == 0 && codec.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
